[hdl/pcc_pkg.sv]
`default_nettype none

package pcc_pkg;

  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [1:0] {
    VERDICT_CONVEX     = 2'd0,
    VERDICT_NOT_CONVEX = 2'd1,
    VERDICT_FEW        = 2'd2
  } verdict_t;

  // control that travels with one vertex down the pipe
  typedef struct packed {
    logic valid;
    logic last;
    logic few;  // polygon ends with fewer than three vertices
    logic en;   // the turn lanes carry real triples
  } ctl_t;

  localparam int LANES = 3;

endpackage

`default_nettype wire

[hdl/pcc_if.sv]
`default_nettype none

interface pcc_vertex_if #(
  parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         is_last;

  modport source (output valid, vertex_x, vertex_y, is_last, input ready);
  modport sink (input valid, vertex_x, vertex_y, is_last, output ready);
endinterface

interface pcc_verdict_if;
  logic             valid;
  logic             ready;
  pcc_pkg::verdict_t verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

`default_nettype wire

[hdl/pcc_front.sv]
`default_nettype none

module pcc_front #(
  parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         advance,
  input  wire logic                         in_valid,
  input  wire logic signed [COORD_BITS-1:0] in_x,
  input  wire logic signed [COORD_BITS-1:0] in_y,
  input  wire logic                         in_last,
  output pcc_pkg::ctl_t                     ctl,
  output logic signed [COORD_BITS:0]        diff [pcc_pkg::LANES][4]
);
  import pcc_pkg::*;

  localparam int CB = COORD_BITS;

  logic signed [CB-1:0] first_x, first_y, second_x, second_y;
  logic signed [CB-1:0] older_x, older_y, newer_x, newer_y;
  logic [1:0]           seen_count;
  logic [1:0]           seen_count_next;
  logic                 accept;
  logic signed [CB-1:0] px [LANES][3];
  logic signed [CB-1:0] py [LANES][3];
  logic signed [CB:0]   diff_next [LANES][4];

  assign accept = in_valid && advance;

  always_comb begin
    if (in_last) begin
      seen_count_next = 2'd0;
    end else if (seen_count == 2'd3) begin
      seen_count_next = 2'd3;
    end else begin
      seen_count_next = seen_count + 2'd1;
    end
  end

  // triples: (older,newer,v), (newer,v,first), (v,first,second)
  always_comb begin
    px[0][0] = older_x;  py[0][0] = older_y;
    px[0][1] = newer_x;  py[0][1] = newer_y;
    px[0][2] = in_x;     py[0][2] = in_y;
    px[1][0] = newer_x;  py[1][0] = newer_y;
    px[1][1] = in_x;     py[1][1] = in_y;
    px[1][2] = first_x;  py[1][2] = first_y;
    px[2][0] = in_x;     py[2][0] = in_y;
    px[2][1] = first_x;  py[2][1] = first_y;
    px[2][2] = second_x; py[2][2] = second_y;
    for (int i = 0; i < LANES; i++) begin
      diff_next[i][0] = {px[i][1][CB-1], px[i][1]} - {px[i][0][CB-1], px[i][0]};
      diff_next[i][1] = {py[i][2][CB-1], py[i][2]} - {py[i][1][CB-1], py[i][1]};
      diff_next[i][2] = {py[i][1][CB-1], py[i][1]} - {py[i][0][CB-1], py[i][0]};
      diff_next[i][3] = {px[i][2][CB-1], px[i][2]} - {px[i][1][CB-1], px[i][1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= 2'd0;
      ctl        <= '0;
    end else if (advance) begin
      ctl.valid <= accept;
      ctl.last  <= in_last;
      ctl.few   <= seen_count < 2'd2;
      ctl.en    <= seen_count >= 2'd2;
      if (accept) begin
        seen_count <= seen_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (seen_count == 2'd0) begin
        first_x <= in_x;
        first_y <= in_y;
      end
      if (seen_count == 2'd1) begin
        second_x <= in_x;
        second_y <= in_y;
      end
      older_x <= newer_x;
      older_y <= newer_y;
      newer_x <= in_x;
      newer_y <= in_y;
    end
    if (advance) begin
      diff <= diff_next;
    end
  end

endmodule

`default_nettype wire

[hdl/pcc_turn.sv]
`default_nettype none

module pcc_turn #(
  parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     advance,
  input  wire logic signed [COORD_BITS:0] diff [4],
  output logic                          pos,
  output logic                          neg
);
  localparam int PW = 2 * COORD_BITS + 2;

  logic signed [PW-1:0] prod_a;
  logic signed [PW-1:0] prod_b;

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_a <= PW'(diff[0]) * PW'(diff[1]);
      prod_b <= PW'(diff[2]) * PW'(diff[3]);
    end
  end

  assign pos = prod_a > prod_b;
  assign neg = prod_a < prod_b;

endmodule

`default_nettype wire

[hdl/pcc_verdict.sv]
`default_nettype none

module pcc_verdict (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire pcc_pkg::ctl_t  ctl_in,
  input  wire logic           pos [pcc_pkg::LANES],
  input  wire logic           neg [pcc_pkg::LANES],
  output logic                advance,
  pcc_verdict_if.source       res
);
  import pcc_pkg::*;

  ctl_t     ctl;
  logic     saw_positive;
  logic     saw_negative;
  logic     any_pos;
  logic     any_neg;
  logic     all_pos;
  logic     all_neg;
  verdict_t verdict_next;

  assign advance = !res.valid || res.ready;

  always_comb begin
    any_pos = 1'b0;
    any_neg = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      if (i == 0 || ctl.last) begin
        any_pos = any_pos | pos[i];
        any_neg = any_neg | neg[i];
      end
    end
    all_pos = saw_positive || (ctl.en && any_pos);
    all_neg = saw_negative || (ctl.en && any_neg);
    if (ctl.few) begin
      verdict_next = VERDICT_FEW;
    end else if (all_pos && all_neg) begin
      verdict_next = VERDICT_NOT_CONVEX;
    end else begin
      verdict_next = VERDICT_CONVEX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl          <= '0;
      saw_positive <= 1'b0;
      saw_negative <= 1'b0;
      res.valid    <= 1'b0;
    end else if (advance) begin
      ctl       <= ctl_in;
      res.valid <= ctl.valid && ctl.last;
      if (ctl.valid) begin
        saw_positive <= ctl.last ? 1'b0 : all_pos;
        saw_negative <= ctl.last ? 1'b0 : all_neg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.verdict <= verdict_next;
    end
  end

endmodule

`default_nettype wire

[hdl/polygon_convexity_check.sv]
// Polygon convexity check. Vertices arrive one word per cycle on vtx, the
// final vertex of a polygon flagged by is_last; one verdict word per polygon
// leaves on res (convex, not convex, or fewer than three vertices). A new
// vertex is taken every cycle unless the input stalls; the verdict passes the
// difference, multiply and compare stages after the last vertex is taken. The
// input stalls only while a finished verdict waits on res.
`default_nettype none

module polygon_convexity_check #(
  parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  pcc_vertex_if.sink    vtx,
  pcc_verdict_if.source res
);
  import pcc_pkg::*;

  logic               advance;
  ctl_t               ctl;
  logic signed [COORD_BITS:0] diff [LANES][4];
  logic               pos [LANES];
  logic               neg [LANES];

  assign vtx.ready = advance;

  pcc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_valid(vtx.valid),
    .in_x    (vtx.vertex_x),
    .in_y    (vtx.vertex_y),
    .in_last (vtx.is_last),
    .ctl     (ctl),
    .diff    (diff)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    pcc_turn #(.COORD_BITS(COORD_BITS)) u_turn (
      .clk    (clk),
      .advance(advance),
      .diff   (diff[i]),
      .pos    (pos[i]),
      .neg    (neg[i])
    );
  end

  pcc_verdict u_verdict (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (ctl),
    .pos    (pos),
    .neg    (neg),
    .advance(advance),
    .res    (res)
  );

endmodule

`default_nettype wire

[hdl/pcc_checker.sv]
`default_nettype none

module pcc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic vtx_valid,
  input wire logic vtx_ready,
  input wire logic vtx_last,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire logic [1:0] verdict
);
  logic adv;
  logic acc_last;

  assign adv      = !res_valid || res_ready;
  assign acc_last = vtx_valid && vtx_ready && vtx_last;

  a_ready_only_on_backpressure: assert property (@(posedge clk)
    !vtx_ready |-> (res_valid && !res_ready))
    else $error("input stalled without output backpressure");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(verdict)))
    else $error("result word dropped or changed while stalled");

  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    acc_last ##1 adv ##1 adv |=> res_valid)
    else $error("no verdict after last vertex");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid after reset");

endmodule

bind polygon_convexity_check pcc_checker u_pcc_checker (
  .clk      (clk),
  .rst      (rst),
  .vtx_valid(vtx.valid),
  .vtx_ready(vtx.ready),
  .vtx_last (vtx.is_last),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .verdict  (res.verdict)
);

`default_nettype wire
